@@ rtl/mtb_pkg.sv @@
package mtb_pkg;

  // Width of the dimension registers
  localparam int unsigned CFG_W = 6;

  // Dimension register reset values
  localparam logic [CFG_W-1:0] ROW_COUNT_RESET = 6'd32;
  localparam logic [CFG_W-1:0] COL_COUNT_RESET = 6'd32;

  // APB address width and register indexes
  localparam int unsigned PADDR_W = 3;
  localparam logic REG_ROW_COUNT = 1'b0;
  localparam logic REG_COL_COUNT = 1'b1;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_EMIT = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    STAT_LOADED   = 2'd0,
    STAT_EMITTED  = 2'd1,
    STAT_REJECTED = 2'd2
  } stat_e;

  typedef enum logic {
    ST_LOAD = 1'b0,
    ST_EMIT = 1'b1
  } state_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic  clear;
    logic  take;
    logic  load_wr;
    logic  emit_rd;
    stat_e status;
    logic  last;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic load_last;
    logic emit_last;
  } dp_stat_t;

endpackage

@@ rtl/matrix_transpose_buffer.sv @@
// Transpose buffer for a row_count x col_count matrix of raw elements.
// Input channel (in_valid_i / in_stall_o): each word carries operation_i and
// element_i. A load word writes the next element in row-major order; once the
// whole matrix is in, emit words read it back in row-major order of the
// transposed matrix, input (r,c) leaving at position c*row_count+r. The last
// emitted element has last_of_matrix_o set, and the block returns to loading.
// A load while a full matrix waits, or an emit while loading, is rejected.
// Output channel (out_valid_o / out_stall_i): one result word per input word,
// with status_o 0 loaded, 1 emitted, 2 rejected.
// The result of an accepted word is held in the result register; throughput is
// one word per cycle, since each word makes a single store access and the
// result register frees up in the cycle the receiver takes it. While the
// receiver stalls a waiting result, in_stall_o is raised and the result holds.
// Reset empties the output register, returns to loading, clears all
// positions and sets both dimensions to 32. The store is not cleared; every
// read follows a write under the same dimensions. An APB write to row_count
// (address 0) or col_count (address 4) abandons any matrix in progress.
module matrix_transpose_buffer #(
  parameter int unsigned MAX_DIM      = 32,
  parameter int unsigned ELEMENT_BITS = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mtb_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        operation_i,
  input  logic [ELEMENT_BITS-1:0]     element_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [ELEMENT_BITS-1:0]     element_out_o,
  output logic                        last_of_matrix_o,
  output logic [1:0]                  status_o
);
  import mtb_pkg::*;

  logic [CFG_W-1:0] row_count_q, col_count_q;
  logic             cfg_wr;
  cmd_t             cmd;
  dp_stat_t         dp_stat;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  // Dimension registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q <= ROW_COUNT_RESET;
      col_count_q <= COL_COUNT_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_ROW_COUNT) begin
        row_count_q <= pwdata[CFG_W-1:0];
      end else begin
        col_count_q <= pwdata[CFG_W-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_COL_COUNT) ? 32'(col_count_q) : 32'(row_count_q);

  mtb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .operation_i (operation_i),
    .out_stall_i (out_stall_i),
    .cfg_clear_i (cfg_wr),
    .dp_stat_i   (dp_stat),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd)
  );

  mtb_datapath #(
    .MAX_DIM      (MAX_DIM),
    .ELEMENT_BITS (ELEMENT_BITS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .row_count_i      (row_count_q),
    .col_count_i      (col_count_q),
    .element_i        (element_i),
    .cmd_i            (cmd),
    .dp_stat_o        (dp_stat),
    .element_out_o    (element_out_o),
    .last_of_matrix_o (last_of_matrix_o),
    .status_o         (status_o)
  );

endmodule

@@ rtl/mtb_ctrl.sv @@
module mtb_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              operation_i,
  input  logic              out_stall_i,
  input  logic              cfg_clear_i,
  input  mtb_pkg::dp_stat_t dp_stat_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  output mtb_pkg::cmd_t     cmd_o
);
  import mtb_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;

  // Hold the input while a finished word waits downstream
  assign in_stall_o  = out_valid_q & out_stall_i;
  assign accept      = in_valid_i & ~in_stall_o;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Decide status and commands for the accepted word
  always_comb begin
    state_d       = state_q;
    cmd_o.clear   = cfg_clear_i;
    cmd_o.take    = accept;
    cmd_o.load_wr = 1'b0;
    cmd_o.emit_rd = 1'b0;
    cmd_o.status  = STAT_REJECTED;
    cmd_o.last    = 1'b0;
    if (accept) begin
      case (state_q)
        ST_LOAD: begin
          if (op_e'(operation_i) == OP_LOAD) begin
            cmd_o.load_wr = 1'b1;
            cmd_o.status  = STAT_LOADED;
            if (dp_stat_i.load_last) begin
              state_d = ST_EMIT;
            end
          end
        end
        ST_EMIT: begin
          if (op_e'(operation_i) == OP_EMIT) begin
            cmd_o.emit_rd = 1'b1;
            cmd_o.status  = STAT_EMITTED;
            cmd_o.last    = dp_stat_i.emit_last;
            if (dp_stat_i.emit_last) begin
              state_d = ST_LOAD;
            end
          end
        end
        default: state_d = ST_LOAD;
      endcase
    end
    // Abandon any matrix in progress on a dimension write
    if (cfg_clear_i) begin
      state_d = ST_LOAD;
    end
  end

  // Keep the result word until it is taken
  always_comb begin
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (out_stall_i) begin
      out_valid_d = out_valid_q;
    end else begin
      out_valid_d = 1'b0;
    end
  end

endmodule

@@ rtl/mtb_datapath.sv @@
module mtb_datapath #(
  parameter int unsigned MAX_DIM      = 32,
  parameter int unsigned ELEMENT_BITS = 32
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [mtb_pkg::CFG_W-1:0] row_count_i,
  input  logic [mtb_pkg::CFG_W-1:0] col_count_i,
  input  logic [ELEMENT_BITS-1:0]   element_i,
  input  mtb_pkg::cmd_t             cmd_i,
  output mtb_pkg::dp_stat_t         dp_stat_o,
  output logic [ELEMENT_BITS-1:0]   element_out_o,
  output logic                      last_of_matrix_o,
  output logic [1:0]                status_o
);
  import mtb_pkg::*;

  localparam int unsigned IDX_W  = $clog2(MAX_DIM);
  localparam int unsigned DEPTH  = MAX_DIM * MAX_DIM;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned CMP_W  = (CFG_W > IDX_W + 1) ? CFG_W : IDX_W + 1;

  logic [IDX_W-1:0]        load_row_q, load_col_q, emit_row_q, emit_col_q;
  logic [IDX_W-1:0]        rows_m1, cols_m1;
  logic [CMP_W-1:0]        rows_ext, cols_ext;
  logic [ADDR_W-1:0]       wr_addr, rd_addr;
  logic [ELEMENT_BITS-1:0] element_store_q [DEPTH];
  logic [ELEMENT_BITS-1:0] rd_data_q;
  stat_e                   status_q;
  logic                    last_q;

  // Clamp dimensions to 1..MAX_DIM and take the last index
  assign rows_ext = CMP_W'(row_count_i);
  assign cols_ext = CMP_W'(col_count_i);

  always_comb begin
    if (rows_ext == '0) begin
      rows_m1 = '0;
    end else if (rows_ext > CMP_W'(MAX_DIM)) begin
      rows_m1 = IDX_W'(MAX_DIM - 1);
    end else begin
      rows_m1 = IDX_W'(rows_ext - CMP_W'(1));
    end
    if (cols_ext == '0) begin
      cols_m1 = '0;
    end else if (cols_ext > CMP_W'(MAX_DIM)) begin
      cols_m1 = IDX_W'(MAX_DIM - 1);
    end else begin
      cols_m1 = IDX_W'(cols_ext - CMP_W'(1));
    end
  end

  assign dp_stat_o.load_last = (load_col_q == cols_m1) & (load_row_q == rows_m1);
  assign dp_stat_o.emit_last = (emit_col_q == rows_m1) & (emit_row_q == cols_m1);

  // Input (r,c) sits at r*MAX_DIM+c; emit reads column-wise
  assign wr_addr = ADDR_W'(load_row_q) * ADDR_W'(MAX_DIM) + ADDR_W'(load_col_q);
  assign rd_addr = ADDR_W'(emit_col_q) * ADDR_W'(MAX_DIM) + ADDR_W'(emit_row_q);

  // Advance the load and emit positions
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_row_q <= '0;
      load_col_q <= '0;
      emit_row_q <= '0;
      emit_col_q <= '0;
      status_q   <= STAT_LOADED;
      last_q     <= 1'b0;
    end else begin
      if (cmd_i.take) begin
        status_q <= cmd_i.status;
        last_q   <= cmd_i.last;
      end
      if (cmd_i.clear) begin
        load_row_q <= '0;
        load_col_q <= '0;
        emit_row_q <= '0;
        emit_col_q <= '0;
      end else begin
        if (cmd_i.load_wr) begin
          if (load_col_q == cols_m1) begin
            load_col_q <= '0;
            load_row_q <= (load_row_q == rows_m1) ? '0 : load_row_q + 1'b1;
          end else begin
            load_col_q <= load_col_q + 1'b1;
          end
        end
        if (cmd_i.emit_rd) begin
          if (emit_col_q == rows_m1) begin
            emit_col_q <= '0;
            emit_row_q <= (emit_row_q == cols_m1) ? '0 : emit_row_q + 1'b1;
          end else begin
            emit_col_q <= emit_col_q + 1'b1;
          end
        end
      end
    end
  end

  // Element store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_wr) begin
      element_store_q[wr_addr] <= element_i;
    end
    if (cmd_i.emit_rd) begin
      rd_data_q <= element_store_q[rd_addr];
    end
  end

  // Drive zero data unless the word is an emitted element
  assign element_out_o    = (status_q == STAT_EMITTED) ? rd_data_q : '0;
  assign last_of_matrix_o = last_q;
  assign status_o         = status_q;

endmodule

@@ rtl/mtb_checker.sv @@
module mtb_checker #(
  parameter int unsigned ELEMENT_BITS = 32
) (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_stall_o,
  input logic                    out_valid_o,
  input logic                    out_stall_i,
  input logic [ELEMENT_BITS-1:0] element_out_o,
  input logic                    last_of_matrix_o,
  input logic [1:0]              status_o
);
  import mtb_pkg::*;

  // An accepted word yields a result word on the next cycle
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o)
    else $error("accepted word produced no result");

  // Only emitted elements carry data
  a_zero_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != STAT_EMITTED |-> element_out_o == '0)
    else $error("nonzero data on a word that is not an emitted element");

  // The end-of-matrix flag marks an emitted element only
  a_last_emitted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_of_matrix_o |-> status_o == STAT_EMITTED)
    else $error("last flag on a word that is not an emitted element");

  // A stalled result word holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(element_out_o)
      && $stable(status_o) && $stable(last_of_matrix_o))
    else $error("stalled result word changed");

endmodule

bind matrix_transpose_buffer mtb_checker #(
  .ELEMENT_BITS (ELEMENT_BITS)
) u_mtb_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_stall_o       (in_stall_o),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .element_out_o    (element_out_o),
  .last_of_matrix_o (last_of_matrix_o),
  .status_o         (status_o)
);
